[rtl/sos_pkg.sv]
`default_nettype none
package sos_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  localparam logic [4:0]  MAX_OBJECTS = 5'd15;
  localparam logic [16:0] SUM_MAX     = 17'h1FFFF;
  localparam logic [9:0]  MEAN_MAX    = 10'd1023;
  localparam logic [4:0]  DIV_STEPS   = 5'd17;

  localparam logic [9:0] NEAR_RESET = 10'd10;
  localparam logic [9:0] FAR_RESET  = 10'd100;
  localparam logic [7:0] MINW_RESET = 8'd5;

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_NEAR = 2'd0;
  localparam cfg_addr_t CFG_FAR  = 2'd1;
  localparam cfg_addr_t CFG_MINW = 2'd2;

  typedef struct packed {
    logic [3:0]  idx;
    logic [7:0]  mid;
    logic [7:0]  width;
    logic [16:0] sum;
    logic [7:0]  divisor;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } div_state_t;

endpackage
`default_nettype wire

[rtl/sos_front.sv]
`default_nettype none
module sos_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire sos_pkg::cfg_addr_t cfg_addr,
  input  wire logic [9:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        angle,
  input  wire logic [9:0]        ir,
  input  wire logic [9:0]        sonar,
  input  wire logic              first,
  input  wire logic              q_full,
  output logic                   push,
  output sos_pkg::job_t          push_job
);

  logic [9:0]  near_r, far_r;
  logic [7:0]  minw_r;
  logic        in_obj_r, in_obj_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [16:0] sum_r, sum_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  logic        acc, in_win, in_obj_eff, open_obj, close_obj, reversed, emit;
  logic [16:0] sum_eff;
  logic [4:0]  cnt_eff;
  logic [7:0]  width;
  logic [8:0]  angle_sum;
  logic [17:0] sum_add;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    in_win     = (ir >= near_r) && (ir <= far_r);
    in_obj_eff = first ? 1'b0 : in_obj_r;
    sum_eff    = first ? 17'd0 : sum_r;
    cnt_eff    = first ? 5'd0 : cnt_r;
    open_obj   = in_win && !in_obj_eff && !first;
    close_obj  = !in_win && in_obj_eff;
    reversed   = angle < start_r;
    width      = angle - start_r;
    angle_sum  = {1'b0, start_r} + {1'b0, angle};
    sum_add    = {1'b0, sum_eff} + {8'd0, sonar};
    emit       = close_obj && !reversed && (width >= minw_r) && (cnt_eff < sos_pkg::MAX_OBJECTS);

    in_obj_nxt = in_obj_r;
    start_nxt  = start_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    if (acc) begin
      in_obj_nxt = in_obj_eff;
      sum_nxt    = sum_eff;
      cnt_nxt    = cnt_eff;
      priority if (open_obj) begin
        in_obj_nxt = 1'b1;
        start_nxt  = angle;
        sum_nxt    = {7'd0, sonar};
      end else if (close_obj) begin
        in_obj_nxt = 1'b0;
        if (emit) cnt_nxt = cnt_eff + 5'd1;
      end else if (in_obj_eff) begin
        sum_nxt = sum_add[17] ? sos_pkg::SUM_MAX : sum_add[16:0];
      end
    end

    push             = acc && emit;
    push_job.idx     = cnt_eff[3:0];
    push_job.mid     = angle_sum[8:1];
    push_job.width   = width;
    push_job.sum     = sum_eff;
    push_job.divisor = {1'b0, width[7:1]} + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r   <= sos_pkg::NEAR_RESET;
      far_r    <= sos_pkg::FAR_RESET;
      minw_r   <= sos_pkg::MINW_RESET;
      in_obj_r <= 1'b0;
      start_r  <= 8'd0;
      sum_r    <= 17'd0;
      cnt_r    <= 5'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          sos_pkg::CFG_NEAR: near_r <= cfg_wdata;
          sos_pkg::CFG_FAR:  far_r  <= cfg_wdata;
          sos_pkg::CFG_MINW: minw_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      in_obj_r <= in_obj_nxt;
      start_r  <= start_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_emit_wide: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_job.width >= minw_r) && (push_job.divisor != 8'd0))
    else $error("object emitted below minimum width");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sos_pkg::MAX_OBJECTS)
    else $error("object count past limit");

endmodule
`default_nettype wire

[rtl/sos_queue.sv]
`default_nettype none
module sos_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sos_pkg::job_t push_job,
  input  wire logic          pop,
  output sos_pkg::job_t      head,
  output logic               full,
  output logic               empty
);

  sos_pkg::job_t mem [sos_pkg::QDepth];
  logic [sos_pkg::QPtrW-1:0] wr_r, rd_r;
  logic [sos_pkg::QCntW-1:0] cnt_r;

  assign full  = cnt_r == sos_pkg::QCntW'(sos_pkg::QDepth);
  assign empty = cnt_r == '0;
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wr_r <= wr_r + 1'b1;
      if (pop && !empty) rd_r <= rd_r + 1'b1;
      unique case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + sos_pkg::QCntW'(1);
        2'b01:   cnt_r <= cnt_r - sos_pkg::QCntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[rtl/sos_div.sv]
`default_nettype none
module sos_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire sos_pkg::job_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         out_idx,
  output logic [7:0]         out_mid,
  output logic [7:0]         out_width,
  output logic [9:0]         out_mean
);

  sos_pkg::div_state_t state_r, state_nxt;
  logic [16:0] q_r, q_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  div_r;
  logic [4:0]  step_r, step_nxt;
  logic [3:0]  idx_r;
  logic [7:0]  mid_r, width_r;
  logic [9:0]  mean_r;
  logic [8:0]  trial;
  logic        qbit;

  assign pop       = (state_r == sos_pkg::ST_IDLE) && !q_empty;
  assign out_valid = state_r == sos_pkg::ST_OUT;
  assign out_idx   = idx_r;
  assign out_mid   = mid_r;
  assign out_width = width_r;
  assign out_mean  = mean_r;

  always_comb begin
    trial   = {rem_r, q_r[16]};
    qbit    = trial >= {1'b0, div_r};
    rem_nxt = qbit ? 8'(trial - {1'b0, div_r}) : trial[7:0];
    q_nxt   = {q_r[15:0], qbit};
    step_nxt  = step_r - 5'd1;
    state_nxt = state_r;
    unique case (state_r)
      sos_pkg::ST_IDLE: if (!q_empty) state_nxt = sos_pkg::ST_DIV;
      sos_pkg::ST_DIV:  if (step_r == 5'd1) state_nxt = sos_pkg::ST_OUT;
      sos_pkg::ST_OUT:  if (out_ready) state_nxt = sos_pkg::ST_IDLE;
      default:          state_nxt = sos_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sos_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q_r     <= head.sum;
      rem_r   <= 8'd0;
      div_r   <= head.divisor;
      step_r  <= sos_pkg::DIV_STEPS;
      idx_r   <= head.idx;
      mid_r   <= head.mid;
      width_r <= head.width;
    end else if (state_r == sos_pkg::ST_DIV) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_nxt;
      if (step_r == 5'd1) mean_r <= (|q_nxt[16:10]) ? sos_pkg::MEAN_MAX : q_nxt[9:0];
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sos_pkg::ST_DIV) |-> (div_r != 8'd0) && (rem_r < div_r))
    else $error("divider remainder out of range");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sos_pkg::ST_DIV) |-> (step_r != 5'd0) && (step_r <= sos_pkg::DIV_STEPS))
    else $error("divider step count out of range");

endmodule
`default_nettype wire

[rtl/scan_object_segmenter_unit.sv]
`default_nettype none
// splits a sweep of range samples into objects. a sample is accepted whenever
// the two-entry job queue has room; each closing object that is reported
// passes through the restoring divider (17 quotient bits, one bit per cycle)
// that forms the mean sonar distance; the divider takes the next object only
// after its result is accepted, and the input stalls only when two reported objects
// wait behind the divider. configuration writes take effect on the next cycle.
module scan_object_segmenter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [9:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // angle_deg, ir_cm, sonar_cm, zero fill
  input  wire logic        in_tuser,   // sweep_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // object_index, middle_angle_deg, angular_width_deg,
                                       // mean_distance_cm, zero fill
);

  logic          push, pop, q_full, q_empty;
  sos_pkg::job_t push_job, head;
  logic [3:0]    o_idx;
  logic [7:0]    o_mid, o_width;
  logic [9:0]    o_mean;

  sos_front u_front (
    .clk, .rst_n, .cfg_we,
    .cfg_addr  (sos_pkg::cfg_addr_t'(cfg_addr)),
    .cfg_wdata,
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .angle     (in_tdata[7:0]),
    .ir        (in_tdata[17:8]),
    .sonar     (in_tdata[27:18]),
    .first     (in_tuser),
    .q_full,
    .push,
    .push_job
  );

  sos_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head,
    .full  (q_full),
    .empty (q_empty)
  );

  sos_div u_div (
    .clk, .rst_n, .q_empty, .head, .pop,
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (o_idx),
    .out_mid   (o_mid),
    .out_width (o_width),
    .out_mean  (o_mean)
  );

  assign out_tdata = {2'b00, o_mean, o_width, o_mid, o_idx};

endmodule
`default_nettype wire
